// ===== rtl/core/urdc_pkg.sv =====
// Package for the UART reply datagram checker.
// Holds the word types, opcode and status codes, register indexes and the CRC-8 step.
// Depends on nothing.
package urdc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned REG_W    = 7;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_REPLY = 2'd1;
    localparam logic [1:0] ST_FORMAT   = 2'd2;
    localparam logic [1:0] ST_BAD_CRC  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 1'd1;

    localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'h05;
    localparam logic [BYTE_W-1:0] MASTER_RESET = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h07;
    localparam logic [DATA_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;

    localparam logic [CNT_W-1:0] CNT_MASTER = 4'd1;
    localparam logic [CNT_W-1:0] CNT_REG    = 4'd2;
    localparam logic [CNT_W-1:0] CNT_DATA   = 4'd3;
    localparam logic [CNT_W-1:0] CNT_LAST   = 4'd7;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] rx_byte;
        logic [REG_W-1:0]  reg_addr;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] reg_data;
    } t_out_word;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] master_addr;
    } t_cfg;

    // One byte of CRC-8, data bits taken least significant first.
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = crc;
        for (int k = 0; k < BYTE_W; k++) begin
            fb = c[BYTE_W-1] ^ data[k];
            c  = {c[BYTE_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/urdc_in_reg.sv =====
// Input register of the UART reply datagram checker.
// Holds one input word until the frame logic takes it; uses urdc_pkg.
module urdc_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  urdc_pkg::t_in_word  i_data,
    input  logic                i_advance,
    output logic                o_valid,
    output urdc_pkg::t_in_word  o_data
);

    logic               r_valid;
    urdc_pkg::t_in_word r_data;

    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== rtl/core/urdc_frame.sv =====
// Frame state of the UART reply datagram checker: sync hunt, header checks,
// CRC-8 and data collection. Produces at most one result per word; uses urdc_pkg.
module urdc_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  urdc_pkg::t_in_word  i_data,
    input  urdc_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output urdc_pkg::t_out_word o_data
);

    logic [urdc_pkg::CNT_W-1:0]  r_count, n_count;
    logic [urdc_pkg::BYTE_W-1:0] r_crc, n_crc;
    logic [urdc_pkg::DATA_W-1:0] r_shift, n_shift;
    logic [urdc_pkg::REG_W-1:0]  r_expected, n_expected;
    logic                        r_hdr_bad, n_hdr_bad;
    logic                        r_armed, n_armed;

    logic [urdc_pkg::BYTE_W-1:0] crc_next;

    assign crc_next = urdc_pkg::crc8_byte(r_crc, i_data.rx_byte);

    always_comb begin
        n_count    = r_count;
        n_crc      = r_crc;
        n_shift    = r_shift;
        n_expected = r_expected;
        n_hdr_bad  = r_hdr_bad;
        n_armed    = r_armed;
        o_valid    = 1'b0;
        o_data.status   = urdc_pkg::ST_NO_REPLY;
        o_data.reg_data = urdc_pkg::ALL_ONES;
        if (i_valid) begin
            unique case (i_data.opcode)
                urdc_pkg::OP_START: begin
                    n_count    = '0;
                    n_crc      = '0;
                    n_shift    = '0;
                    n_hdr_bad  = 1'b0;
                    n_expected = i_data.reg_addr;
                    n_armed    = 1'b1;
                end
                urdc_pkg::OP_TIMEOUT: begin
                    if (r_armed) begin
                        o_valid   = 1'b1;
                        n_count   = '0;
                        n_crc     = '0;
                        n_shift   = '0;
                        n_hdr_bad = 1'b0;
                        n_armed   = 1'b0;
                    end
                end
                urdc_pkg::OP_BYTE: begin
                    if (r_armed && !(r_count == '0 && i_data.rx_byte != i_cfg.sync_value)) begin
                        if (r_count < urdc_pkg::CNT_LAST) begin
                            n_crc   = crc_next;
                            n_count = r_count + 1'b1;
                            if (r_count == urdc_pkg::CNT_MASTER
                                    && i_data.rx_byte != i_cfg.master_addr) begin
                                n_hdr_bad = 1'b1;
                            end
                            if (r_count == urdc_pkg::CNT_REG
                                    && i_data.rx_byte != {1'b0, r_expected}) begin
                                n_hdr_bad = 1'b1;
                            end
                            if (r_count >= urdc_pkg::CNT_DATA) begin
                                n_shift = {r_shift[urdc_pkg::DATA_W-urdc_pkg::BYTE_W-1:0],
                                           i_data.rx_byte};
                            end
                        end else begin
                            o_valid = 1'b1;
                            if (r_hdr_bad) begin
                                o_data.status = urdc_pkg::ST_FORMAT;
                            end else if (r_crc != i_data.rx_byte) begin
                                o_data.status = urdc_pkg::ST_BAD_CRC;
                            end else begin
                                o_data.status   = urdc_pkg::ST_OK;
                                o_data.reg_data = r_shift;
                            end
                            n_count   = '0;
                            n_crc     = '0;
                            n_shift   = '0;
                            n_hdr_bad = 1'b0;
                            n_armed   = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= '0;
            r_shift    <= '0;
            r_expected <= '0;
            r_hdr_bad  <= 1'b0;
            r_armed    <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_shift    <= n_shift;
            r_expected <= n_expected;
            r_hdr_bad  <= n_hdr_bad;
            r_armed    <= n_armed;
        end
    end

endmodule

// ===== rtl/core/uart_reply_datagram_checker.sv =====
// Top level of the UART reply datagram checker.
// Instantiates urdc_in_reg and urdc_frame, holds the configuration and output
// registers; uses urdc_pkg.
//
// The input channel (i_valid, o_stall, i_data) carries one word per event:
// a start of a register read with its address, a received byte, or a reply
// timeout. The output channel (o_valid, i_stall, o_data) carries one word per
// finished reply or timeout: a status and the 32-bit register value, which is
// all ones on any error. Starts, dropped bytes and the first seven reply bytes
// give no output word.
// A word is taken on every cycle in which o_stall is low; its result, if any,
// passes through the input register and is then held in the output register
// until it is taken.
// The CRC-8 update of one byte is done combinationally after the input register.
// With i_cfg_we high, the configuration port writes the sync value (index 0)
// or master address (index 1); users must write only while idle (not enforced).
// Synchronous reset clears both registers, disarms the checker and sets the
// sync value to 5 and the master address to 255.
// When the receiver stalls, the output word holds; the input register still
// takes one more word, after which o_stall rises until the output is taken.
module uart_reply_datagram_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  urdc_pkg::t_in_word                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output urdc_pkg::t_out_word                 o_data,
    input  logic                                i_cfg_we,
    input  logic [urdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [urdc_pkg::BYTE_W-1:0]         i_cfg_data
);

    urdc_pkg::t_cfg      r_cfg;
    logic                r_out_valid;
    urdc_pkg::t_out_word r_out_data;

    logic                advance;
    logic                in_valid;
    urdc_pkg::t_in_word  in_data;
    logic                res_valid;
    urdc_pkg::t_out_word res_data;

    assign advance = !r_out_valid || !i_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    urdc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_data    (in_data)
    );

    urdc_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid && advance),
        .i_data  (in_data),
        .i_cfg   (r_cfg),
        .o_valid (res_valid),
        .o_data  (res_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value  <= urdc_pkg::SYNC_RESET;
            r_cfg.master_addr <= urdc_pkg::MASTER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                urdc_pkg::CFG_SYNC:   r_cfg.sync_value  <= i_cfg_data;
                urdc_pkg::CFG_MASTER: r_cfg.master_addr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && in_valid && res_valid) begin
            r_out_data <= res_data;
        end
    end

endmodule

// ===== rtl/core/urdc_checker.sv =====
// Port-level assertions for the UART reply datagram checker.
// Bound to uart_reply_datagram_checker; uses urdc_pkg.
module urdc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input urdc_pkg::t_out_word            o_data
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

    a_error_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != urdc_pkg::ST_OK |-> o_data.reg_data == urdc_pkg::ALL_ONES)
        else $error("error status without all-ones data");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the output side is free");

endmodule

bind uart_reply_datagram_checker urdc_checker u_urdc_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for uart_reply_datagram_checker.
// Drives start, byte and timeout words, predicts each reply status and value in
// its own datagram tracker and compares field by field; depends on urdc_pkg.
module testbench;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         DRAIN_WAIT = 6;
    localparam int         CYCLE_LIMIT = 400000;

    logic                phase_clk_unused_guard;
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    urdc_pkg::t_in_word  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    urdc_pkg::t_out_word o_data;
    logic                                 i_cfg_we = 1'b0;
    logic [urdc_pkg::CFG_IDX_W-1:0]       i_cfg_idx = urdc_pkg::CFG_SYNC;
    logic [urdc_pkg::BYTE_W-1:0]          i_cfg_data = '0;

    assign phase_clk_unused_guard = i_clk;

    uart_reply_datagram_checker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Datagram tracker state and its copy of the configuration.
    logic [urdc_pkg::BYTE_W-1:0] cfg_sync = urdc_pkg::SYNC_RESET;
    logic [urdc_pkg::BYTE_W-1:0] cfg_master = urdc_pkg::MASTER_RESET;
    logic [urdc_pkg::CNT_W-1:0]  rx_count = '0;
    logic [urdc_pkg::BYTE_W-1:0] rx_crc = '0;
    logic [urdc_pkg::DATA_W-1:0] rx_data = '0;
    logic [urdc_pkg::REG_W-1:0]  want_reg = '0;
    bit                          hdr_mismatch = 1'b0;
    bit                          awaiting = 1'b0;

    urdc_pkg::t_out_word awaited_replies[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        fails = 0;
    int        effective_words = 0;
    int        total_words = 0;
    int        status_seen[4] = '{0, 0, 0, 0};
    int        cycles = 0;

    function automatic logic [urdc_pkg::BYTE_W-1:0] crc8_next(
            input logic [urdc_pkg::BYTE_W-1:0] crc,
            input logic [urdc_pkg::BYTE_W-1:0] b);
        logic [urdc_pkg::BYTE_W-1:0] c;
        c = crc;
        for (int i = 0; i < urdc_pkg::BYTE_W; i++) begin
            c = (c[urdc_pkg::BYTE_W-1] ^ b[i])
                ? ({c[urdc_pkg::BYTE_W-2:0], 1'b0} ^ urdc_pkg::CRC_POLY)
                : {c[urdc_pkg::BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void clear_reply();
        rx_count = '0;
        rx_crc = '0;
        rx_data = '0;
        hdr_mismatch = 1'b0;
    endfunction

    // Returns 1 when the word changed the tracker state or produced a reply.
    function automatic bit track_datagram(input urdc_pkg::t_in_word w);
        urdc_pkg::t_out_word r;
        case (w.opcode)
            urdc_pkg::OP_START: begin
                clear_reply();
                want_reg = w.reg_addr;
                awaiting = 1'b1;
                return 1'b1;
            end
            urdc_pkg::OP_TIMEOUT: begin
                if (!awaiting) return 1'b0;
                r.status = urdc_pkg::ST_NO_REPLY;
                r.reg_data = urdc_pkg::ALL_ONES;
                awaited_replies.push_back(r);
                clear_reply();
                awaiting = 1'b0;
                return 1'b1;
            end
            urdc_pkg::OP_BYTE: begin
                if (!awaiting) return 1'b0;
                if (rx_count == '0 && w.rx_byte != cfg_sync) return 1'b0;
                if (rx_count < urdc_pkg::CNT_LAST) begin
                    rx_crc = crc8_next(rx_crc, w.rx_byte);
                    if (rx_count == urdc_pkg::CNT_MASTER && w.rx_byte != cfg_master)
                        hdr_mismatch = 1'b1;
                    if (rx_count == urdc_pkg::CNT_REG && w.rx_byte != {1'b0, want_reg})
                        hdr_mismatch = 1'b1;
                    if (rx_count >= urdc_pkg::CNT_DATA)
                        rx_data = {rx_data[urdc_pkg::DATA_W-urdc_pkg::BYTE_W-1:0], w.rx_byte};
                    rx_count = rx_count + 1'b1;
                    return 1'b1;
                end
                if (hdr_mismatch) begin
                    r.status = urdc_pkg::ST_FORMAT;
                    r.reg_data = urdc_pkg::ALL_ONES;
                end else if (rx_crc != w.rx_byte) begin
                    r.status = urdc_pkg::ST_BAD_CRC;
                    r.reg_data = urdc_pkg::ALL_ONES;
                end else begin
                    r.status = urdc_pkg::ST_OK;
                    r.reg_data = rx_data;
                end
                awaited_replies.push_back(r);
                clear_reply();
                awaiting = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [urdc_pkg::BYTE_W-1:0] rx,
                             input logic [urdc_pkg::REG_W-1:0] addr);
        urdc_pkg::t_in_word w;
        w.opcode = op;
        w.rx_byte = (op == urdc_pkg::OP_BYTE || op == OP_UNUSED)
                    ? rx : urdc_pkg::BYTE_W'($urandom);
        w.reg_addr = (op == urdc_pkg::OP_START || op == OP_UNUSED)
                     ? addr : urdc_pkg::REG_W'($urandom);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (o_stall);
        total_words++;
        if (track_datagram(w)) effective_words++;
    endtask

    // Sends a reply opening with the current sync byte; cut < 8 ends it with a timeout.
    task automatic send_reply(input logic [urdc_pkg::BYTE_W-1:0] b1,
                              input logic [urdc_pkg::BYTE_W-1:0] b2,
                              input logic [urdc_pkg::DATA_W-1:0] value,
                              input logic [urdc_pkg::BYTE_W-1:0] crc_xor, input int cut);
        logic [urdc_pkg::BYTE_W-1:0] frame[8];
        logic [urdc_pkg::BYTE_W-1:0] crc;
        frame[0] = cfg_sync;
        frame[1] = b1;
        frame[2] = b2;
        frame[3] = value[31:24];
        frame[4] = value[23:16];
        frame[5] = value[15:8];
        frame[6] = value[7:0];
        crc = '0;
        for (int i = 0; i < 7; i++) crc = crc8_next(crc, frame[i]);
        frame[7] = crc ^ crc_xor;
        for (int i = 0; i < cut && i < 8; i++) send_word(urdc_pkg::OP_BYTE, frame[i], '0);
        if (cut < 8) send_word(urdc_pkg::OP_TIMEOUT, '0, '0);
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (awaited_replies.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [urdc_pkg::BYTE_W-1:0] sync,
                              input logic [urdc_pkg::BYTE_W-1:0] master);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= urdc_pkg::CFG_SYNC;
        i_cfg_data <= sync;
        @(posedge i_clk);
        cfg_sync = sync;
        i_cfg_idx <= urdc_pkg::CFG_MASTER;
        i_cfg_data <= master;
        @(posedge i_clk);
        cfg_master = master;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_ignored_words();
        send_word(urdc_pkg::OP_BYTE, 8'hFF, '0);
        send_word(urdc_pkg::OP_TIMEOUT, '0, '0);
        send_word(OP_UNUSED, 8'hFF, 7'h7F);
    endtask

    task automatic test_timeout_and_restart();
        send_word(urdc_pkg::OP_START, '0, 7'h00);
        send_word(urdc_pkg::OP_START, '0, 7'h7F);
        send_word(urdc_pkg::OP_TIMEOUT, '0, '0);
    endtask

    task automatic test_good_reply();
        send_word(urdc_pkg::OP_START, '0, 7'h7F);
        send_word(urdc_pkg::OP_BYTE, 8'h00, '0);
        send_reply(cfg_master, 8'h7F, 32'hFF00_A55A, 8'h00, 8);
    endtask

    task automatic test_format_over_crc();
        send_word(urdc_pkg::OP_START, '0, 7'h05);
        send_reply(cfg_master, 8'h85, 32'h0000_0000, 8'hFF, 8);
    endtask

    task automatic test_random_traffic(input int words);
        int                          target;
        int                          r;
        logic [urdc_pkg::REG_W-1:0]  addr;
        logic [urdc_pkg::BYTE_W-1:0] noise;
        logic [urdc_pkg::BYTE_W-1:0] b1;
        logic [urdc_pkg::BYTE_W-1:0] b2;
        logic [urdc_pkg::DATA_W-1:0] value;
        target = effective_words + words;
        while (effective_words < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                addr = urdc_pkg::REG_W'($urandom_range(0, 127));
                if ($urandom_range(0, 4) == 0)
                    send_word(urdc_pkg::OP_START, '0, urdc_pkg::REG_W'($urandom));
                send_word(urdc_pkg::OP_START, '0, addr);
                repeat ($urandom_range(0, 2)) begin
                    noise = urdc_pkg::BYTE_W'($urandom);
                    if (noise == cfg_sync) noise = ~noise;
                    send_word(urdc_pkg::OP_BYTE, noise, '0);
                end
                b1 = ($urandom_range(0, 9) == 0) ? urdc_pkg::BYTE_W'($urandom) : cfg_master;
                if ($urandom_range(0, 9) == 0)
                    b2 = $urandom_range(0, 1) ? {1'b1, addr} : urdc_pkg::BYTE_W'($urandom);
                else
                    b2 = {1'b0, addr};
                case ($urandom_range(0, 9))
                    0: value = '0;
                    1: value = urdc_pkg::ALL_ONES;
                    default: value = $urandom;
                endcase
                send_reply(b1, b2, value,
                           ($urandom_range(0, 9) == 0)
                           ? urdc_pkg::BYTE_W'($urandom_range(1, 255)) : '0,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8);
            end else if (r < 85) begin
                send_word(urdc_pkg::OP_START, '0, urdc_pkg::REG_W'($urandom));
                repeat ($urandom_range(0, 3))
                    send_word(urdc_pkg::OP_BYTE, urdc_pkg::BYTE_W'($urandom), '0);
                send_word(urdc_pkg::OP_TIMEOUT, '0, '0);
            end else begin
                send_word(2'($urandom_range(0, 3)), urdc_pkg::BYTE_W'($urandom),
                          urdc_pkg::REG_W'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        urdc_pkg::t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_replies.size() == 0) begin
                $error("unexpected reply: status %0d, reg_data %h", o_data.status,
                       o_data.reg_data);
                fails++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_data.status);
                    fails++;
                end
                if (o_data.reg_data !== want.reg_data) begin
                    $error("reg_data: expected %h, actual %h", want.reg_data, o_data.reg_data);
                    fails++;
                end
                status_seen[want.status]++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 24;
        recv_stall_pct = 47;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_words();
        test_timeout_and_restart();
        test_good_reply();
        test_format_over_crc();

        wait_idle();
        set_config(8'h00, 8'h00);
        test_random_traffic(270);
        wait_idle();
        set_config(8'hFF, 8'hFF);
        test_random_traffic(270);

        send_idle_pct = 47;
        recv_stall_pct = 24;
        wait_idle();
        set_config(urdc_pkg::BYTE_W'($urandom), urdc_pkg::BYTE_W'($urandom));
        test_random_traffic(270);
        wait_idle();
        set_config(8'hA5, 8'h00);
        test_random_traffic(270);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();
        set_config(8'h00, 8'hFF);
        test_random_traffic(270);
        wait_idle();
        set_config(urdc_pkg::BYTE_W'($urandom), urdc_pkg::BYTE_W'($urandom));
        test_random_traffic(270);
        wait_idle();

        if (awaited_replies.size() != 0) begin
            $error("%0d replies never arrived", awaited_replies.size());
            fails++;
        end
        $display("Sent %0d words (%0d acted on) over six configurations and three idle mixes.",
                 total_words, effective_words);
        $display("Replies: %0d ok, %0d no reply, %0d invalid format, %0d bad CRC.",
                 status_seen[urdc_pkg::ST_OK], status_seen[urdc_pkg::ST_NO_REPLY],
                 status_seen[urdc_pkg::ST_FORMAT], status_seen[urdc_pkg::ST_BAD_CRC]);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
